@@ design/tier_quota_usage_tracker_defines.svh @@
// Assertion macros used by the update engine (tqut_back).
`ifndef TIER_QUOTA_USAGE_TRACKER_DEFINES_SVH
`define TIER_QUOTA_USAGE_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TQUT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TQUT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tqut_pkg.sv @@
// Shared types and codes for the usage tracker.
`default_nettype none
package tqut_pkg;

	localparam int USAGE_W = 32;
	localparam int NODE_W = 3;
	localparam int GROUP_W = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_DEMOTE = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_PROMOTE = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MASKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MASKS = 2'd3;

	typedef enum logic [1:0] {
		OP_IGNORE,
		OP_INC,
		OP_DEC,
		OP_NOMATCH
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [GROUP_W-1:0] grp;
		logic [NODE_W-1:0]  node;
		logic [USAGE_W-1:0] pages;
	} item_t;

endpackage
`default_nettype wire

@@ design/tqut_front.sv @@
// Front end: configuration registers, item accept and group classification.
`default_nettype none
module tqut_front #(
	parameter int NODE_COUNT = 8,
	parameter int GROUP_COUNT = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tqut_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tqut_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [tqut_pkg::NODE_W-1:0]     source_node,
	input  wire logic [tqut_pkg::NODE_W-1:0]     dest_node,
	input  wire logic [tqut_pkg::USAGE_W-1:0]    page_count,
	input  wire logic                            q_full,
	output logic                                 push,
	output tqut_pkg::item_t                      item
);
	import tqut_pkg::*;

	logic                  enable_q;
	logic [2:0]            group_count_q;
	logic [USAGE_W-1:0]    local_masks_q;
	logic [USAGE_W-1:0]    target_masks_q;
	logic                  found;
	op_t                   op;
	logic [GROUP_W-1:0]    grp;
	logic [NODE_W-1:0]     node;

	function automatic logic mask_has(input logic [USAGE_W-1:0] mask, input int g,
			input logic [NODE_W-1:0] nd);
		int pos;
		pos = g * NODE_COUNT + int'(nd);
		return (int'(nd) < NODE_COUNT) && (pos < USAGE_W) && mask[pos[4:0]];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			group_count_q <= '0;
			local_masks_q <= '0;
			target_masks_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_GROUP_COUNT: group_count_q <= cfg_data[2:0];
				CFG_LOCAL_MASKS: local_masks_q <= cfg_data;
				CFG_TARGET_MASKS: target_masks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// first qualifying group wins; increase check before decrease check
	always_comb begin
		found = 1'b0;
		op = OP_NOMATCH;
		grp = '0;
		node = '0;
		for (int g = 0; g < GROUP_COUNT; g++) begin
			if (!found && (g < int'(group_count_q))) begin
				if (mask_has(local_masks_q, g, source_node) &&
						mask_has(target_masks_q, g, dest_node)) begin
					found = 1'b1;
					op = OP_INC;
					grp = GROUP_W'(g);
					node = dest_node;
				end else if (mask_has(local_masks_q, g, dest_node) &&
						mask_has(target_masks_q, g, source_node)) begin
					found = 1'b1;
					op = OP_DEC;
					grp = GROUP_W'(g);
					node = source_node;
				end
			end
		end
		if (!enable_q || (page_count == '0)) begin
			op = OP_IGNORE;
			grp = '0;
			node = '0;
		end
	end

	assign busy = q_full;
	assign push = start && !busy;
	assign item = '{op: op, grp: grp, node: node, pages: page_count};

endmodule
`default_nettype wire

@@ design/tqut_queue.sv @@
// Short item queue between the front end and the update engine.
`default_nettype none
module tqut_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tqut_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output tqut_pkg::item_t      head
);
	import tqut_pkg::*;

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/tqut_back.sv @@
// Update engine: usage store read-modify-write and result registers.
`default_nettype none
`include "tier_quota_usage_tracker_defines.svh"
module tqut_back #(
	parameter int NODE_COUNT = 8,
	parameter int GROUP_COUNT = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          empty,
	input  wire tqut_pkg::item_t               head,
	output logic                               pop,
	output logic                               done,
	output logic [tqut_pkg::STATUS_W-1:0]      status,
	output logic [tqut_pkg::GROUP_W-1:0]       group_index,
	output logic [tqut_pkg::NODE_W-1:0]        target_node,
	output logic [tqut_pkg::USAGE_W-1:0]       usage_after
);
	import tqut_pkg::*;

	localparam int STORE_DEPTH = GROUP_COUNT * NODE_COUNT;
	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_FETCH = 2'b01,
		ST_APPLY = 2'b10
	} back_state_t;

	back_state_t         state_q;
	logic [USAGE_W-1:0]  mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	item_t               item_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [USAGE_W-1:0]  rd_data_s1;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    head_idx;
	logic [USAGE_W-1:0]  cur;
	logic [USAGE_W:0]    sum;
	logic [USAGE_W:0]    diff;
	logic [USAGE_W-1:0]  new_usage;
	logic [STATUS_W-1:0] new_status;
	logic                wr_en;
	logic                apply;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [GROUP_W-1:0]  group_q;
	logic [NODE_W-1:0]   node_q;
	logic [USAGE_W-1:0]  usage_q;

	assign head_idx = IDX_W'(int'(head.grp) * NODE_COUNT + int'(head.node));
	assign pop = (state_q == ST_FETCH) && !empty;
	assign apply = (state_q == ST_APPLY);

	always_comb begin
		cur = rd_vld_s1 ? rd_data_s1 : '0;
		sum = {1'b0, cur} + {1'b0, item_s1.pages};
		diff = {1'b0, cur} - {1'b0, item_s1.pages};
		new_usage = '0;
		new_status = STATUS_NOMATCH;
		wr_en = 1'b0;
		case (item_s1.op)
			OP_INC: begin
				new_usage = sum[USAGE_W] ? '1 : sum[USAGE_W-1:0];
				new_status = STATUS_DEMOTE;
				wr_en = apply;
			end
			OP_DEC: begin
				new_usage = diff[USAGE_W] ? '0 : diff[USAGE_W-1:0];
				new_status = diff[USAGE_W] ? STATUS_CLAMPED : STATUS_PROMOTE;
				wr_en = apply;
			end
			OP_IGNORE: new_status = STATUS_IGNORED;
			default: new_status = STATUS_NOMATCH;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_s1] <= new_usage;
		end
		if (pop) begin
			item_s1 <= head;
			idx_s1 <= head_idx;
			rd_data_s1 <= mem_q[head_idx];
			rd_vld_s1 <= vld_q[head_idx];
		end
		if (apply) begin
			status_q <= new_status;
			group_q <= wr_en ? item_s1.grp : '0;
			node_q <= wr_en ? item_s1.node : '0;
			usage_q <= new_usage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= apply;
			if (wr_en) begin
				vld_q[idx_s1] <= 1'b1;
			end
			case (state_q)
				ST_FETCH: begin
					if (pop) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: state_q <= ST_FETCH;
				default: state_q <= ST_FETCH;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign group_index = group_q;
	assign target_node = node_q;
	assign usage_after = usage_q;

	`TQUT_ASSERT_IMPLY(a_no_pop_in_apply, apply, !pop, "queue popped during update")
	`TQUT_ASSERT_NEXT(a_pop_to_apply, pop, apply, "pop not followed by update")
	`TQUT_ASSERT_NEXT(a_apply_to_done, apply, done && !apply, "update gave no single result")
	`TQUT_ASSERT_IMPLY(a_quiet_fields, done && (status == STATUS_IGNORED || status == STATUS_NOMATCH), group_index == '0 && target_node == '0 && usage_after == '0, "non-zero fields without update")
	`TQUT_ASSERT_IMPLY(a_clamp_zero, done && status == STATUS_CLAMPED, usage_after == '0, "clamped usage not zero")

endmodule
`default_nettype wire

@@ design/tier_quota_usage_tracker.sv @@
// Top level of the far-memory usage tracker.
// Usage:
//   Configuration: write registers through cfg_valid/cfg_ready with cfg_index
//   (0 enable, 1 group count, 2 local node masks, 3 target node masks) and
//   cfg_data; cfg_ready is always high. Write only while no item is in flight.
//   Items: drive start with source_node, dest_node and page_count; the item is
//   taken at a rising edge where start is high and busy is low.
//   Results: every item gives exactly one result, shown for one cycle with
//   done high on status, group_index, target_node and usage_after.
//   Path: an accepted item goes through the queue, the fetch state (pop and
//   store read) and the apply state (write back); results are registered.
//   The update engine alternates fetch and apply on the usage store, so it
//   takes no new item until the last one has been written back.
//   A two-entry queue decouples accept from update; busy is high while full.
//   Reset: arst_n clears configuration, queue and the valid bit of every usage entry, so every entry reads as zero.
//   The receiver cannot stall: results must be taken in the cycle shown.
`default_nettype none
module tier_quota_usage_tracker #(
	parameter int NODE_COUNT = 8,
	parameter int GROUP_COUNT = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tqut_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tqut_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [tqut_pkg::NODE_W-1:0]     source_node,
	input  wire logic [tqut_pkg::NODE_W-1:0]     dest_node,
	input  wire logic [tqut_pkg::USAGE_W-1:0]    page_count,
	output logic                                 done,
	output logic [tqut_pkg::STATUS_W-1:0]        status,
	output logic [tqut_pkg::GROUP_W-1:0]         group_index,
	output logic [tqut_pkg::NODE_W-1:0]          target_node,
	output logic [tqut_pkg::USAGE_W-1:0]         usage_after
);
	import tqut_pkg::*;

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	tqut_front #(
		.NODE_COUNT (NODE_COUNT),
		.GROUP_COUNT(GROUP_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.source_node(source_node),
		.dest_node  (dest_node),
		.page_count (page_count),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	tqut_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	tqut_back #(
		.NODE_COUNT (NODE_COUNT),
		.GROUP_COUNT(GROUP_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.status     (status),
		.group_index(group_index),
		.target_node(target_node),
		.usage_after(usage_after)
	);

endmodule
`default_nettype wire
